/* hw/rtl/bavg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared types and constants of the block-average downsampler.
// ----------------------------------------------------------------------------
package bavg_pkg;

    localparam int LED_SIZE_DEF = 16;
    localparam int MAX_DIM_DEF  = 4096;

    localparam int CFG_W   = 13;   // image_width / image_height register width
    localparam int CH_W    = 8;    // one color channel
    localparam int SUM_W   = 24;   // one channel accumulator
    localparam int IDX_W   = 4;    // block_x / block_y port width
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a pixel
        S_DIMS,   // block width/height being derived
        S_AREA,   // block area, start position re-derivation
        S_POS,    // raster position being mapped onto the block grid
        S_ACC,    // accumulator read data back, write updated sums
        S_AVG,    // dividing the block sums by the area
        S_OUT     // hand the averages to the output register
    } t_state;

endpackage : bavg_pkg
`default_nettype wire

/* hw/rtl/bavg_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bavg_div
// Restoring divider, one quotient bit per cycle. Results hold until the
// next start.
// ----------------------------------------------------------------------------
module bavg_div #(
    parameter int NW = 24,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [NW-1:0]      o_quotient,
    output logic [DW-1:0]      o_remainder
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;

    logic [DW:0]     shifted;
    logic            ge;
    logic [DW:0]     diff;

    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule : bavg_div
`default_nettype wire

/* hw/rtl/bavg_acc_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bavg_acc_mem
// Column-block accumulator memory: one entry of packed RGB sums per block
// column, registered read, with per-entry valid bits so an unwritten or
// cleared entry reads as zero.
// ----------------------------------------------------------------------------
module bavg_acc_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 72
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear_all,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0]      o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear_all) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            // a frame start clears on the same edge as its first read
            if (i_rd_en) begin
                r_rd_valid <= !i_clear_all && r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule : bavg_acc_mem
`default_nettype wire

/* hw/rtl/block_average_downsampler_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_downsampler_top
// Box-filter downsampler: raster RGB pixels in, one averaged RGB per block out.
// ----------------------------------------------------------------------------
// A pixel outside every whole block is accepted from the idle state alone; a
// pixel inside a block also passes an accumulator memory read, then a write
// back; the last pixel of a block then waits for the bit-serial sum/area
// division (24 quotient bits and the done flag) and for the load of the output
// register, which waits while an earlier result still waits at the output. A
// register write holds the input during its setup and access cycles. After
// reset and after each register write the block re-derives block size and
// grid position before the next pixel is taken.
module block_average_downsampler_top
    import bavg_pkg::*;
#(
    parameter int LED_SIZE = LED_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_start_of_frame,
    input  wire logic [CH_W-1:0]   i_red,
    input  wire logic [CH_W-1:0]   i_green,
    input  wire logic [CH_W-1:0]   i_blue,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [IDX_W-1:0]       o_block_x,
    output logic [IDX_W-1:0]       o_block_y,
    output logic [CH_W-1:0]        o_avg_red,
    output logic [CH_W-1:0]        o_avg_green,
    output logic [CH_W-1:0]        o_avg_blue,
    output logic                   o_last_of_frame,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int DIMW = $clog2(MAX_DIM + 1);
    localparam int BXW  = $clog2(LED_SIZE + 1);
    localparam int IW   = $clog2(LED_SIZE);
    localparam int ARW  = 2 * DIMW;
    localparam int MDW  = 3 * SUM_W;
    localparam int RSH  = DIMW + BXW;
    localparam int PW   = DIMW + RSH + 1;
    localparam longint unsigned RCP =
        ((64'd1 << RSH) + 64'(LED_SIZE) - 64'd1) / 64'(LED_SIZE);

    t_state r_state, n_state;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic             r_dirty;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(16);
            r_cfg_h <= CFG_W'(16);
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_IMAGE_WIDTH:  r_cfg_w <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= pwdata[CFG_W-1:0];
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg_w);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg_h);
            default:          prdata = '0;
        endcase
    end

    logic [DIMW-1:0] eff_w, eff_h;
    assign eff_w = (32'(r_cfg_w) > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(r_cfg_w);
    assign eff_h = (32'(r_cfg_h) > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(r_cfg_h);

    // ---------------- geometry and raster position ----------------
    logic [DIMW-1:0] r_bw, r_bh;
    logic [ARW-1:0]  r_area;
    logic [DIMW-1:0] r_col, r_row, r_sx, r_sy;
    logic [BXW-1:0]  r_bx, r_by;

    logic [DIMW-1:0] e_col, e_row, e_sx, e_sy;
    logic [BXW-1:0]  e_bx, e_by;
    logic            in_region, emit_blk, accept;
    logic [DIMW-1:0] a_col, a_row, a_sx, a_sy;
    logic [BXW-1:0]  a_bx, a_by;

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        e_col = i_start_of_frame ? '0 : r_col;
        e_row = i_start_of_frame ? '0 : r_row;
        e_sx  = i_start_of_frame ? '0 : r_sx;
        e_sy  = i_start_of_frame ? '0 : r_sy;
        e_bx  = i_start_of_frame ? '0 : r_bx;
        e_by  = i_start_of_frame ? '0 : r_by;

        in_region = (r_bw != '0) && (r_bh != '0)
                 && (e_bx < BXW'(LED_SIZE)) && (e_by < BXW'(LED_SIZE));
        emit_blk  = in_region && (e_sx == r_bw - 1'b1) && (e_sy == r_bh - 1'b1);

        a_col = e_col;
        a_row = e_row;
        a_sx  = e_sx;
        a_sy  = e_sy;
        a_bx  = e_bx;
        a_by  = e_by;
        if ({1'b0, e_col} + 1'b1 >= {1'b0, eff_w}) begin
            a_col = '0;
            a_sx  = '0;
            a_bx  = '0;
            if ({1'b0, e_row} + 1'b1 >= {1'b0, eff_h}) begin
                a_row = '0;
                a_sy  = '0;
                a_by  = '0;
            end else begin
                a_row = e_row + 1'b1;
                if (r_bh != '0 && e_by < BXW'(LED_SIZE)) begin
                    if (e_sy == r_bh - 1'b1) begin
                        a_sy = '0;
                        a_by = e_by + 1'b1;
                    end else begin
                        a_sy = e_sy + 1'b1;
                    end
                end
            end
        end else begin
            a_col = e_col + 1'b1;
            if (r_bw != '0 && e_bx < BXW'(LED_SIZE)) begin
                if (e_sx == r_bw - 1'b1) begin
                    a_sx = '0;
                    a_bx = e_bx + 1'b1;
                end else begin
                    a_sx = e_sx + 1'b1;
                end
            end
        end
    end

    // ---------------- dividers ----------------
    logic            dim_start, pos_start;
    logic            pc_done, pr_done;
    logic [PW-1:0]   bw_prod, bh_prod;
    logic [DIMW-1:0] dw_q, dh_q, pc_q, pr_q;
    logic [DIMW-1:0] pc_r, pr_r;

    assign dim_start = (r_state == S_IDLE) && r_dirty;
    assign pos_start = (r_state == S_AREA);

    // block width and height: multiply by the rounded-up reciprocal of the
    // grid size, exact for every dimension that fits DIMW bits
    assign bw_prod = PW'(eff_w) * PW'(RCP);
    assign bh_prod = PW'(eff_h) * PW'(RCP);
    assign dw_q    = bw_prod[RSH +: DIMW];
    assign dh_q    = bh_prod[RSH +: DIMW];

    // raster position onto the grid
    bavg_div #(.NW(DIMW), .DW(DIMW)) u_div_col (
        .i_clk, .i_rst_n, .i_start(pos_start),
        .i_dividend(r_col), .i_divisor(r_bw),
        .o_done(pc_done), .o_quotient(pc_q), .o_remainder(pc_r)
    );
    bavg_div #(.NW(DIMW), .DW(DIMW)) u_div_row (
        .i_clk, .i_rst_n, .i_start(pos_start),
        .i_dividend(r_row), .i_divisor(r_bh),
        .o_done(pr_done), .o_quotient(pr_q), .o_remainder(pr_r)
    );

    logic col_out, row_out;
    assign col_out = (r_bw == '0) || (pc_q >= DIMW'(LED_SIZE));
    assign row_out = (r_bh == '0) || (pr_q >= DIMW'(LED_SIZE));

    // ---------------- accumulator memory ----------------
    logic [MDW-1:0]  rd_data;
    logic [MDW-1:0]  wr_data;
    logic            mem_rd, mem_wr;
    logic [IW-1:0]   r_idx;
    logic            r_emit;
    logic [BXW-1:0]  r_obx, r_oby;
    logic [CH_W-1:0] r_pr, r_pg, r_pb;

    assign mem_rd = accept && in_region;
    assign mem_wr = (r_state == S_ACC);

    bavg_acc_mem #(.DEPTH(LED_SIZE), .AW(IW), .DW(MDW)) u_mem (
        .i_clk, .i_rst_n,
        .i_clear_all(accept && i_start_of_frame),
        .i_rd_en(mem_rd), .i_rd_addr(e_bx[IW-1:0]), .o_rd_data(rd_data),
        .i_wr_en(mem_wr), .i_wr_addr(r_idx), .i_wr_data(wr_data)
    );

    logic [SUM_W:0]   add_r, add_g, add_b;
    logic [SUM_W-1:0] s_r, s_g, s_b;

    always_comb begin
        add_r = {1'b0, rd_data[3*SUM_W-1:2*SUM_W]} + (SUM_W+1)'(r_pr);
        add_g = {1'b0, rd_data[2*SUM_W-1:SUM_W]}   + (SUM_W+1)'(r_pg);
        add_b = {1'b0, rd_data[SUM_W-1:0]}         + (SUM_W+1)'(r_pb);
        // saturate on carry out
        s_r   = add_r[SUM_W] ? '1 : add_r[SUM_W-1:0];
        s_g   = add_g[SUM_W] ? '1 : add_g[SUM_W-1:0];
        s_b   = add_b[SUM_W] ? '1 : add_b[SUM_W-1:0];
        wr_data = r_emit ? '0 : {s_r, s_g, s_b};
    end

    // ---------------- block averages ----------------
    logic             avg_start;
    logic             ar_done, ag_done, ab_done;
    logic [SUM_W-1:0] ar_q, ag_q, ab_q;

    assign avg_start = (r_state == S_ACC) && r_emit;

    bavg_div #(.NW(SUM_W), .DW(ARW)) u_div_r (
        .i_clk, .i_rst_n, .i_start(avg_start), .i_dividend(s_r), .i_divisor(r_area),
        .o_done(ar_done), .o_quotient(ar_q), .o_remainder()
    );
    bavg_div #(.NW(SUM_W), .DW(ARW)) u_div_g (
        .i_clk, .i_rst_n, .i_start(avg_start), .i_dividend(s_g), .i_divisor(r_area),
        .o_done(ag_done), .o_quotient(ag_q), .o_remainder()
    );
    bavg_div #(.NW(SUM_W), .DW(ARW)) u_div_b (
        .i_clk, .i_rst_n, .i_start(avg_start), .i_dividend(s_b), .i_divisor(r_area),
        .o_done(ab_done), .o_quotient(ab_q), .o_remainder()
    );

    logic out_load;

    // ---------------- control ----------------
    assign o_in_ready = (r_state == S_IDLE) && !r_dirty && !(psel && pwrite);

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    n_state = S_DIMS;
                end else if (mem_rd) begin
                    n_state = S_ACC;
                end
            end
            S_DIMS: n_state = S_AREA;
            S_AREA: n_state = S_POS;
            S_POS:  if (pc_done && pr_done) n_state = S_IDLE;
            S_ACC:  n_state = r_emit ? S_AVG : S_IDLE;
            S_AVG:  if (ar_done && ag_done && ab_done) n_state = S_OUT;
            S_OUT: begin
                if (!o_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dirty <= 1'b1;
            r_col   <= '0;
            r_row   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_bx    <= '0;
            r_by    <= '0;
        end else begin
            r_state <= n_state;
            // a write during re-derivation forces another pass
            if (cfg_wr) begin
                r_dirty <= 1'b1;
            end else if (dim_start) begin
                r_dirty <= 1'b0;
            end
            if (accept) begin
                r_col <= a_col;
                r_row <= a_row;
                r_sx  <= a_sx;
                r_sy  <= a_sy;
                r_bx  <= a_bx;
                r_by  <= a_by;
            end else if (r_state == S_POS && pc_done && pr_done) begin
                r_bx <= col_out ? BXW'(LED_SIZE) : BXW'(pc_q);
                r_sx <= col_out ? '0 : pc_r;
                r_by <= row_out ? BXW'(LED_SIZE) : BXW'(pr_q);
                r_sy <= row_out ? '0 : pr_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIMS) begin
            r_bw <= dw_q;
            r_bh <= dh_q;
        end
        if (r_state == S_AREA) begin
            r_area <= ARW'(r_bw * r_bh);
        end
        if (accept) begin
            r_idx  <= e_bx[IW-1:0];
            r_emit <= emit_blk;
            r_obx  <= e_bx;
            r_oby  <= e_by;
            r_pr   <= i_red;
            r_pg   <= i_green;
            r_pb   <= i_blue;
        end
    end

    // ---------------- output register ----------------
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_block_x       <= IDX_W'(r_obx);
            o_block_y       <= IDX_W'(r_oby);
            o_avg_red       <= (ar_q > SUM_W'(255)) ? '1 : ar_q[CH_W-1:0];
            o_avg_green     <= (ag_q > SUM_W'(255)) ? '1 : ag_q[CH_W-1:0];
            o_avg_blue      <= (ab_q > SUM_W'(255)) ? '1 : ab_q[CH_W-1:0];
            o_last_of_frame <= (r_obx == BXW'(LED_SIZE - 1))
                            && (r_oby == BXW'(LED_SIZE - 1));
        end
    end

    assign o_out_valid = r_ovalid;

endmodule : block_average_downsampler_top
`default_nettype wire

/* tb/tb_block_average_downsampler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_downsampler_top
// Streams raster RGB frames through the downsampler under random valid/ready
// gaps, predicts each block average in a local model and compares every
// result transfer field by field. Image sizes are changed over APB between
// phases.
// ----------------------------------------------------------------------------

class bavg_scoreboard;

    typedef struct packed {
        logic [3:0] bx;
        logic [3:0] by;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } t_block_avg;

    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned col;
    int unsigned row;
    int unsigned acc_r[16];
    int unsigned acc_g[16];
    int unsigned acc_b[16];
    t_block_avg  pending[$];
    int          errors;
    int          results_seen;

    function new();
        width_reg  = 16;
        height_reg = 16;
        col        = 0;
        row        = 0;
        errors     = 0;
        results_seen = 0;
        clear_acc();
    endfunction

    function void clear_acc();
        foreach (acc_r[i]) begin
            acc_r[i] = 0;
            acc_g[i] = 0;
            acc_b[i] = 0;
        end
    endfunction

    function int unsigned sat24(int unsigned s, int unsigned v);
        return (s + v > 24'hFFFFFF) ? 24'hFFFFFF : s + v;
    endfunction

    function logic [7:0] mean(int unsigned s, int unsigned area);
        return (s / area > 255) ? 8'd255 : 8'(s / area);
    endfunction

    function void note_pixel(logic sof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, bw, bh, bx, by, area;
        t_block_avg  e;
        w  = (width_reg > 4096) ? 4096 : width_reg;
        h  = (height_reg > 4096) ? 4096 : height_reg;
        bw = w / 16;
        bh = h / 16;
        if (sof) begin
            col = 0;
            row = 0;
            clear_acc();
        end
        if (bw != 0 && bh != 0 && col < bw * 16 && row < bh * 16) begin
            bx = col / bw;
            by = row / bh;
            acc_r[bx] = sat24(acc_r[bx], r);
            acc_g[bx] = sat24(acc_g[bx], g);
            acc_b[bx] = sat24(acc_b[bx], b);
            if (col % bw == bw - 1 && row % bh == bh - 1) begin
                area   = bw * bh;
                e.bx   = 4'(bx);
                e.by   = 4'(by);
                e.r    = mean(acc_r[bx], area);
                e.g    = mean(acc_g[bx], area);
                e.b    = mean(acc_b[bx], area);
                e.last = (bx == 15 && by == 15);
                pending.push_back(e);
                acc_r[bx] = 0;
                acc_g[bx] = 0;
                acc_b[bx] = 0;
            end
        end
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function void check_block(t_block_avg got);
        t_block_avg e;
        results_seen++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected block result %h", got);
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            errors++;
            if (errors <= 10) begin
                $display("block mismatch: expected x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                         e.bx, e.by, e.r, e.g, e.b, e.last);
                $display("                got      x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                         got.bx, got.by, got.r, got.g, got.b, got.last);
            end
        end
    endfunction
endclass

module tb_block_average_downsampler_top
    import bavg_pkg::*;
();

    localparam int SETTLE = 40;
    localparam longint LIMIT = 3000000;

    // pixel patterns of a frame
    localparam int PAT_RANDOM = 0;
    localparam int PAT_MAX    = 1;
    localparam int PAT_ZERO   = 2;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_start_of_frame = 1'b0;
    logic [CH_W-1:0]   i_red = '0;
    logic [CH_W-1:0]   i_green = '0;
    logic [CH_W-1:0]   i_blue = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [IDX_W-1:0]  o_block_x;
    logic [IDX_W-1:0]  o_block_y;
    logic [CH_W-1:0]   o_avg_red;
    logic [CH_W-1:0]   o_avg_green;
    logic [CH_W-1:0]   o_avg_blue;
    logic              o_last_of_frame;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bavg_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    longint cycles = 0;

    block_average_downsampler_top uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_block_average_downsampler_top: FAIL");
            $finish;
        end
    end

    // receiver side: random stalls, check on every transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_block({o_block_x, o_block_y, o_avg_red, o_avg_green,
                                o_avg_blue, o_last_of_frame});
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [12:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            sb.width_reg = val;
        else
            sb.height_reg = val;
    endtask

    task automatic send_pixel(logic sof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_start_of_frame <= sof;
        i_red            <= r;
        i_green          <= g;
        i_blue           <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(sof, r, g, b);
    endtask

    // drop valid right at the edge of the last transfer, then wait until no result is pending
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, int pattern);
        for (int unsigned p = 0; p < w * h; p++) begin
            case (pattern)
                PAT_MAX:  send_pixel(p == 0, 8'hFF, 8'hFF, 8'hFF);
                PAT_ZERO: send_pixel(p == 0, 8'h00, 8'h00, 8'h00);
                default:  send_pixel(p == 0, 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin
        int unsigned w, h;
        int sent;
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // directed: reset size, extremes of pixel values, sub-grid size
        send_frame(16, 16, PAT_MAX);
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'd17);
        write_reg(REG_IMAGE_HEIGHT, 13'd15);
        repeat (SETTLE) @(posedge i_clk);
        send_frame(17, 3, PAT_ZERO);
        drain();
        // mid-frame start of frame and wrap at end of a row
        write_reg(REG_IMAGE_WIDTH, 13'd16);
        write_reg(REG_IMAGE_HEIGHT, 13'd16);
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 20; i++)
            send_pixel(i == 0 || i == 9, 8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        // random phases with different idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 37 : 0;
            sent = 0;
            while (sent < 300) begin
                w = 16;
                h = 16 + 16 * $urandom_range(1);
                if ($urandom_range(9) == 0) w = $urandom_range(31, 16);
                write_reg(REG_IMAGE_WIDTH, 13'(w));
                write_reg(REG_IMAGE_HEIGHT, 13'(h));
                repeat (SETTLE) @(posedge i_clk);
                if ($urandom_range(3) == 0) begin
                    for (int i = 0; i < 60; i++)
                        send_pixel($urandom_range(30) == 0, 8'($urandom),
                                   8'($urandom), 8'($urandom));
                    sent += 60;
                end else begin
                    send_frame(w, h, $urandom_range(5) == 0 ? PAT_MAX : PAT_RANDOM);
                    sent += w * h;
                end
                drain();
            end
        end

        // width above the saturation limit, height at it: only 100 pixels
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 100; i++)
            send_pixel(i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_block_average_downsampler_top: PASS");
        else
            $display("tb_block_average_downsampler_top: FAIL");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/bavg_pkg.sv
hw/rtl/bavg_div.sv
hw/rtl/bavg_acc_mem.sv
hw/rtl/block_average_downsampler_top.sv
tb/tb_block_average_downsampler_top.sv
